// ----- hw/rtl/bdi_pkg.sv -----
// Shared types, size codes and cover-test functions for the BDI line size estimator.
`timescale 1ns / 1ps

package bdi_pkg;

    localparam int LINE_BITS = 512;

    typedef logic [LINE_BITS-1:0] t_line;
    typedef logic [6:0]           t_size;

    localparam logic [63:0] LIM_1B = 64'h0000_0000_0000_00FF;
    localparam logic [63:0] LIM_2B = 64'h0000_0000_0000_FFFF;
    localparam logic [63:0] LIM_4B = 64'h0000_0000_FFFF_FFFF;

    localparam t_size SIZE_ZERO  = 7'd1;
    localparam t_size SIZE_REP4  = 7'd4;
    localparam t_size SIZE_REP8  = 7'd8;
    localparam t_size SIZE_B8D1  = 7'd24;
    localparam t_size SIZE_B4D1  = 7'd24;
    localparam t_size SIZE_B8D2  = 7'd32;
    localparam t_size SIZE_B2D1  = 7'd36;
    localparam t_size SIZE_B4D2  = 7'd40;
    localparam t_size SIZE_B8D4  = 7'd48;
    localparam t_size SIZE_RAW   = 7'd64;

    typedef struct packed {
        t_line       line;
        logic [7:0]  c8d1;
        logic [7:0]  c8d2;
        logic [7:0]  c8d4;
        logic [15:0] c4d1;
        logic [15:0] c4d2;
        logic [31:0] c2d1;
        logic        zero;
        logic        same8;
        logic        same4;
    } t_s1;

    typedef struct packed {
        t_s1         s1;
        logic [63:0] b8d1;
        logic [63:0] b8d2;
        logic [63:0] b8d4;
        logic [31:0] b4d1;
        logic [31:0] b4d2;
        logic [15:0] b2d1;
    } t_s2;

    // |a - b| <= lim on the unwrapped difference
    function automatic logic cov64(input logic [63:0] a, input logic [63:0] b,
                                   input logic [63:0] lim);
        logic [64:0] d;
        d = {1'b0, a} - {1'b0, b};
        return d[64] ? (~d[63:0] < lim) : (d[63:0] <= lim);
    endfunction

    function automatic logic cov32(input logic [31:0] a, input logic [31:0] b,
                                   input logic [31:0] lim);
        logic [32:0] d;
        d = {1'b0, a} - {1'b0, b};
        return d[32] ? (~d[31:0] < lim) : (d[31:0] <= lim);
    endfunction

    function automatic logic cov16(input logic [15:0] a, input logic [15:0] b,
                                   input logic [15:0] lim);
        logic [16:0] d;
        d = {1'b0, a} - {1'b0, b};
        return d[16] ? (~d[15:0] < lim) : (d[15:0] <= lim);
    endfunction

endpackage

// ----- hw/rtl/bdi_cover_stage.sv -----
// Stage 1: cover test of every element against the first base, plus zero and repeat checks.
`timescale 1ns / 1ps

module bdi_cover_stage
    import bdi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_load,
    input  t_line i_line,
    output t_s1   o_q
);

    t_s1 r_q;
    t_s1 n_q;

    always_comb begin
        logic [63:0] e8;
        logic [31:0] e4;
        logic [15:0] e2;
        n_q       = '0;
        n_q.line  = i_line;
        n_q.zero  = (i_line == '0);
        n_q.same8 = 1'b1;
        n_q.same4 = 1'b1;
        for (int i = 0; i < 8; i++) begin
            e8 = i_line[i*64 +: 64];
            n_q.c8d1[i] = cov64(i_line[63:0], e8, LIM_1B);
            n_q.c8d2[i] = cov64(i_line[63:0], e8, LIM_2B);
            n_q.c8d4[i] = cov64(i_line[63:0], e8, LIM_4B);
            if (e8 != i_line[63:0]) begin
                n_q.same8 = 1'b0;
            end
        end
        for (int i = 0; i < 16; i++) begin
            e4 = i_line[i*32 +: 32];
            n_q.c4d1[i] = cov32(i_line[31:0], e4, LIM_1B[31:0]);
            n_q.c4d2[i] = cov32(i_line[31:0], e4, LIM_2B[31:0]);
            if (e4 != i_line[31:0]) begin
                n_q.same4 = 1'b0;
            end
        end
        for (int i = 0; i < 32; i++) begin
            e2 = i_line[i*16 +: 16];
            n_q.c2d1[i] = cov16(i_line[15:0], e2, LIM_1B[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ----- hw/rtl/bdi_base_stage.sv -----
// Stage 2: pick the second base as the first element the first base leaves uncovered.
`timescale 1ns / 1ps

module bdi_base_stage
    import bdi_pkg::*;
(
    input  logic i_clk,
    input  logic i_load,
    input  t_s1  i_d,
    output t_s2  o_q
);

    function automatic logic [63:0] pick64(input t_line line, input logic [7:0] cov);
        logic [7:0]  nc;
        logic [7:0]  oh;
        logic [63:0] b;
        nc = ~cov;
        oh = nc & (~nc + 8'd1);
        b  = '0;
        for (int i = 0; i < 8; i++) begin
            b = b | (line[i*64 +: 64] & {64{oh[i]}});
        end
        return b;
    endfunction

    function automatic logic [31:0] pick32(input t_line line, input logic [15:0] cov);
        logic [15:0] nc;
        logic [15:0] oh;
        logic [31:0] b;
        nc = ~cov;
        oh = nc & (~nc + 16'd1);
        b  = '0;
        for (int i = 0; i < 16; i++) begin
            b = b | (line[i*32 +: 32] & {32{oh[i]}});
        end
        return b;
    endfunction

    function automatic logic [15:0] pick16(input t_line line, input logic [31:0] cov);
        logic [31:0] nc;
        logic [31:0] oh;
        logic [15:0] b;
        nc = ~cov;
        oh = nc & (~nc + 32'd1);
        b  = '0;
        for (int i = 0; i < 32; i++) begin
            b = b | (line[i*16 +: 16] & {16{oh[i]}});
        end
        return b;
    endfunction

    t_s2 r_q;
    t_s2 n_q;

    always_comb begin
        n_q      = '0;
        n_q.s1   = i_d;
        n_q.b8d1 = pick64(i_d.line, i_d.c8d1);
        n_q.b8d2 = pick64(i_d.line, i_d.c8d2);
        n_q.b8d4 = pick64(i_d.line, i_d.c8d4);
        n_q.b4d1 = pick32(i_d.line, i_d.c4d1);
        n_q.b4d2 = pick32(i_d.line, i_d.c4d2);
        n_q.b2d1 = pick16(i_d.line, i_d.c2d1);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ----- hw/rtl/bdi_size_stage.sv -----
// Stage 3: cover test against the second base and selection of the smallest size.
`timescale 1ns / 1ps

module bdi_size_stage
    import bdi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_load,
    input  t_s2   i_d,
    output t_size o_size
);

    function automatic logic ok64(input t_line line, input logic [63:0] base,
                                  input logic [7:0] cov, input logic [63:0] lim);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 8; i++) begin
            ok = ok & (cov[i] | cov64(base, line[i*64 +: 64], lim));
        end
        return ok;
    endfunction

    function automatic logic ok32(input t_line line, input logic [31:0] base,
                                  input logic [15:0] cov, input logic [31:0] lim);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 16; i++) begin
            ok = ok & (cov[i] | cov32(base, line[i*32 +: 32], lim));
        end
        return ok;
    endfunction

    function automatic logic ok16(input t_line line, input logic [15:0] base,
                                  input logic [31:0] cov, input logic [15:0] lim);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 32; i++) begin
            ok = ok & (cov[i] | cov16(base, line[i*16 +: 16], lim));
        end
        return ok;
    endfunction

    t_size r_size;
    t_size n_size;

    always_comb begin
        logic f8d1;
        logic f8d2;
        logic f8d4;
        logic f4d1;
        logic f4d2;
        logic f2d1;
        f8d1 = ok64(i_d.s1.line, i_d.b8d1, i_d.s1.c8d1, LIM_1B);
        f8d2 = ok64(i_d.s1.line, i_d.b8d2, i_d.s1.c8d2, LIM_2B);
        f8d4 = ok64(i_d.s1.line, i_d.b8d4, i_d.s1.c8d4, LIM_4B);
        f4d1 = ok32(i_d.s1.line, i_d.b4d1, i_d.s1.c4d1, LIM_1B[31:0]);
        f4d2 = ok32(i_d.s1.line, i_d.b4d2, i_d.s1.c4d2, LIM_2B[31:0]);
        f2d1 = ok16(i_d.s1.line, i_d.b2d1, i_d.s1.c2d1, LIM_1B[15:0]);
        if (i_d.s1.zero) begin
            n_size = SIZE_ZERO;
        end else if (i_d.s1.same4) begin
            n_size = SIZE_REP4;
        end else if (i_d.s1.same8) begin
            n_size = SIZE_REP8;
        end else if (f8d1) begin
            n_size = SIZE_B8D1;
        end else if (f4d1) begin
            n_size = SIZE_B4D1;
        end else if (f8d2) begin
            n_size = SIZE_B8D2;
        end else if (f2d1) begin
            n_size = SIZE_B2D1;
        end else if (f4d2) begin
            n_size = SIZE_B4D2;
        end else if (f8d4) begin
            n_size = SIZE_B8D4;
        end else begin
            n_size = SIZE_RAW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_size <= n_size;
        end
    end

    assign o_size = r_size;

endmodule

// ----- hw/rtl/bdi_line_size_estimator_unit.sv -----
// Pipeline: an accepted line passes the cover, base select and size stages to a valid size.
// Throughput: one line per cycle; each stage holds while the stage after it is full and stalled.
// A bubble in the pipeline lets a new line in even while the output is stalled.
// Reset: synchronous, active low; clears the three stage valid bits, payload is not reset.
`timescale 1ns / 1ps

module bdi_line_size_estimator_unit
    import bdi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_word0,
    input  logic [63:0] i_word1,
    input  logic [63:0] i_word2,
    input  logic [63:0] i_word3,
    input  logic [63:0] i_word4,
    input  logic [63:0] i_word5,
    input  logic [63:0] i_word6,
    input  logic [63:0] i_word7,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_compressed_size
);

    logic  r_v1;
    logic  r_v2;
    logic  r_v3;
    logic  ready1;
    logic  ready2;
    logic  ready3;
    t_line line;
    t_s1   s1_q;
    t_s2   s2_q;
    t_size size_q;

    assign ready3 = !r_v3 || !i_stall;
    assign ready2 = !r_v2 || ready3;
    assign ready1 = !r_v1 || ready2;

    assign line = {i_word7, i_word6, i_word5, i_word4,
                   i_word3, i_word2, i_word1, i_word0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    bdi_cover_stage u_cover (
        .i_clk  (i_clk),
        .i_load (ready1),
        .i_line (line),
        .o_q    (s1_q)
    );

    bdi_base_stage u_base (
        .i_clk  (i_clk),
        .i_load (ready2),
        .i_d    (s1_q),
        .o_q    (s2_q)
    );

    bdi_size_stage u_size (
        .i_clk  (i_clk),
        .i_load (ready3),
        .i_d    (s2_q),
        .o_size (size_q)
    );

    assign o_stall           = !ready1;
    assign o_valid           = r_v3;
    assign o_compressed_size = size_q;

    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && i_stall) |-> o_stall)
        else $error("full pipeline did not stall input");

    a_mid_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !ready3) |=> r_v2)
        else $error("middle stage dropped a transaction");

    a_size_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_compressed_size == SIZE_ZERO || o_compressed_size == SIZE_REP4 ||
                     o_compressed_size == SIZE_REP8 || o_compressed_size == SIZE_B8D1 ||
                     o_compressed_size == SIZE_B8D2 || o_compressed_size == SIZE_B2D1 ||
                     o_compressed_size == SIZE_B4D2 || o_compressed_size == SIZE_B8D4 ||
                     o_compressed_size == SIZE_RAW))
        else $error("size outside encoding set");

endmodule
